@@ rtl/mbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// shared widths, register map, command/status structs and fixed-point helpers
// for the escape-time unit
// ----------------------------------------------------------------------------
package mbe_pkg;

  // number formats
  localparam int FRAC_BITS = 28;             // fraction bits of internal z
  localparam int ITER_BITS = 16;             // iteration counter width
  localparam int IN_FRAC   = 28;             // fraction bits of c and escape_sq

  // port widths
  localparam int C_W      = 32;
  localparam int ESC_W    = 34;
  localparam int LIM_W    = 16;
  localparam int SCALE_W  = 25;
  localparam int SHADE_W  = 25;
  localparam int ITERS_W  = 16;

  // datapath widths
  localparam int Z_W       = FRAC_BITS + 7;            // signed z, also |z| width
  localparam int ZMAG_BITS = FRAC_BITS + 6;
  localparam int LO_W      = Z_W / 2;                  // low half of multiplier operand
  localparam int HI_W      = Z_W - LO_W;               // high half
  localparam int PP_W      = Z_W + HI_W;               // partial product
  localparam int PROD_W    = 2 * Z_W - FRAC_BITS;      // product after the fraction shift
  localparam int CMP_W     = PROD_W + 1;               // |z|^2 sum
  localparam int SUM_W     = PROD_W + 3;               // z update before saturation
  localparam int SHADE_PROD_W = ITER_BITS + SCALE_W;

  // alignment of Q4.28 inputs to the internal format
  localparam int C_SHL = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
  localparam int C_SHR = (FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;

  localparam logic signed [SUM_W-1:0] Z_HI = SUM_W'((64'sd1 <<< (Z_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] Z_LO = ~Z_HI;
  localparam logic [CMP_W-1:0] MAG_CAP = CMP_W'((64'd1 << ZMAG_BITS) - 64'd1);
  localparam logic [SHADE_W-1:0] SHADE_ONE = SHADE_W'(25'h100_0000);

  // register map
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = ADDR_W - 3;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE_SQ    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER     = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_SCALE_FACTOR = REG_IDX_W'(2);

  localparam logic [ESC_W-1:0]   ESCAPE_SQ_RST    = ESC_W'(34'h0_4000_0000);
  localparam logic [LIM_W-1:0]   MAX_ITER_RST     = LIM_W'(16'd256);
  localparam logic [SCALE_W-1:0] SCALE_FACTOR_RST = SCALE_W'(25'h001_0000);

  // controller to datapath
  typedef struct packed {
    logic load;      // take a new point, clear z and count
    logic mul_lo;    // multiply by low operand halves
    logic mul_hi;    // multiply by high operand halves
    logic sum;       // combine partial products
    logic step;      // escape check and z update
    logic out_load;  // fill the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic esc_hit;   // |z|^2 at or over the bound
    logic lim_hit;   // count after this update reaches the limit
  } status_t;

  function automatic logic signed [SUM_W-1:0] align_c(input logic signed [C_W-1:0] c);
    logic signed [63:0] wide;
    wide = 64'(c);
    wide = (wide <<< C_SHL) >>> C_SHR;
    return SUM_W'(wide);
  endfunction

  function automatic logic [CMP_W-1:0] escape_bound(input logic [ESC_W-1:0] e);
    logic [63:0] wide;
    wide = (64'(e) << C_SHL) >> C_SHR;
    return CMP_W'(wide);
  endfunction

  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] r;
    if (x > Z_HI) begin
      r = Z_HI;
    end else if (x < Z_LO) begin
      r = Z_LO;
    end else begin
      r = x;
    end
    return Z_W'(r);
  endfunction

  function automatic logic [ITER_BITS-1:0] iter_limit(input logic [LIM_W-1:0] m);
    logic [63:0] cap;
    logic [63:0] m64;
    cap = (64'd1 << ITER_BITS) - 64'd1;
    m64 = 64'(m);
    return ITER_BITS'((m64 < cap) ? m64 : cap);
  endfunction

endpackage

@@ rtl/mbe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_ctrl
// sequencer: accepts a point, runs iterations (low half, high half, sum,
// update) until escape or limit, then hands the result to the output register
// ----------------------------------------------------------------------------
module mbe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  mbe_pkg::status_t status_i,
  output mbe_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MLO  = 3'd1;
  localparam logic [2:0] S_MHI  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MLO;
        end
      end
      S_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MHI;
      end
      S_MHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.step = 1'b1;
        if (status_i.esc_hit || status_i.lim_hit) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MLO;
        end
      end
      S_DONE: begin
        // wait for a free output register
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/mbe_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_dp
// datapath: z registers, three split multipliers, magnitude check,
// iteration count and the result register
// ----------------------------------------------------------------------------
module mbe_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mbe_pkg::cmd_t                        cmd_i,
  output mbe_pkg::status_t                     status_o,
  input  logic signed [mbe_pkg::C_W-1:0]       c_re_i,
  input  logic signed [mbe_pkg::C_W-1:0]       c_im_i,
  input  logic [mbe_pkg::ESC_W-1:0]            escape_sq_i,
  input  logic [mbe_pkg::LIM_W-1:0]            max_iter_i,
  input  logic [mbe_pkg::SCALE_W-1:0]          scale_factor_i,
  output logic [mbe_pkg::ITERS_W-1:0]          iterations_o,
  output logic                                 escaped_o,
  output logic [mbe_pkg::SHADE_W-1:0]          shade_o
);

  logic signed [mbe_pkg::SUM_W-1:0]    cr_q, ci_q;
  logic signed [mbe_pkg::Z_W-1:0]      zr_q, zi_q, zr_d, zi_d;
  logic [mbe_pkg::Z_W-1:0]             zr_mag, zi_mag;
  logic [mbe_pkg::Z_W-1:0]             op_a [3];
  logic [mbe_pkg::Z_W-1:0]             b_src [3];
  logic [mbe_pkg::HI_W-1:0]            op_b [3];
  logic [mbe_pkg::PP_W-1:0]            pp [3];
  logic [mbe_pkg::PP_W-1:0]            plo_q [3];
  logic [mbe_pkg::PP_W-1:0]            phi_q [3];
  logic [2*mbe_pkg::Z_W-1:0]           full [3];
  logic [mbe_pkg::PROD_W-1:0]          prod [3];
  logic [mbe_pkg::PROD_W-1:0]          rr_q, ii_q;
  logic signed [mbe_pkg::PROD_W:0]     ri_q, ri_val;
  logic                                ri_neg;
  logic [mbe_pkg::CMP_W-1:0]           mag_sum, mag_sat, bound;
  logic signed [mbe_pkg::SUM_W-1:0]    zr_sum, zi_sum;
  logic [mbe_pkg::ITER_BITS-1:0]       count_q, count_d;
  logic                                first_q, esc_q;
  logic                                esc_hit;
  logic [mbe_pkg::SHADE_PROD_W-1:0]    shade_prod;
  logic [mbe_pkg::SHADE_W-1:0]         shade_sat;
  logic [mbe_pkg::ITERS_W-1:0]         iter_out_q;
  logic                                esc_out_q;
  logic [mbe_pkg::SHADE_W-1:0]         shade_out_q;

  // sign-magnitude operands
  assign zr_mag = zr_q[mbe_pkg::Z_W-1] ? mbe_pkg::Z_W'(-zr_q) : mbe_pkg::Z_W'(zr_q);
  assign zi_mag = zi_q[mbe_pkg::Z_W-1] ? mbe_pkg::Z_W'(-zi_q) : mbe_pkg::Z_W'(zi_q);

  // lanes: zr*zr, zi*zi, zr*zi
  always_comb begin
    op_a[0]  = zr_mag;
    op_a[1]  = zi_mag;
    op_a[2]  = zr_mag;
    b_src[0] = zr_mag;
    b_src[1] = zi_mag;
    b_src[2] = zi_mag;
    for (int k = 0; k < 3; k++) begin
      op_b[k] = cmd_i.mul_hi ? b_src[k][mbe_pkg::Z_W-1:mbe_pkg::LO_W]
                             : mbe_pkg::HI_W'(b_src[k][mbe_pkg::LO_W-1:0]);
      pp[k]   = mbe_pkg::PP_W'(op_a[k]) * mbe_pkg::PP_W'(op_b[k]);
      full[k] = (2*mbe_pkg::Z_W)'(plo_q[k])
              + ((2*mbe_pkg::Z_W)'(phi_q[k]) << mbe_pkg::LO_W);
      prod[k] = mbe_pkg::PROD_W'(full[k] >> mbe_pkg::FRAC_BITS);
    end
  end

  // truncation toward zero: shift the magnitude, then apply the sign
  assign ri_neg = zr_q[mbe_pkg::Z_W-1] ^ zi_q[mbe_pkg::Z_W-1];
  assign ri_val = ri_neg ? -$signed({1'b0, prod[2]}) : $signed({1'b0, prod[2]});

  // squared magnitude of the current z, saturated
  assign mag_sum = mbe_pkg::CMP_W'(rr_q) + mbe_pkg::CMP_W'(ii_q);
  assign mag_sat = (mag_sum > mbe_pkg::MAG_CAP) ? mbe_pkg::MAG_CAP : mag_sum;
  assign bound   = mbe_pkg::escape_bound(escape_sq_i);
  assign esc_hit = !first_q && (mag_sat >= bound);

  // next z
  assign zr_sum = $signed(mbe_pkg::SUM_W'(rr_q)) - $signed(mbe_pkg::SUM_W'(ii_q)) + cr_q;
  assign zi_sum = (mbe_pkg::SUM_W'(ri_q) <<< 1) + ci_q;
  assign zr_d   = mbe_pkg::sat_z(zr_sum);
  assign zi_d   = mbe_pkg::sat_z(zi_sum);

  assign count_d = count_q + mbe_pkg::ITER_BITS'(1);

  assign status_o.esc_hit = esc_hit;
  assign status_o.lim_hit = (count_d >= mbe_pkg::iter_limit(max_iter_i));

  // shade
  assign shade_prod = mbe_pkg::SHADE_PROD_W'(count_q) * mbe_pkg::SHADE_PROD_W'(scale_factor_i);
  assign shade_sat  = (shade_prod > mbe_pkg::SHADE_PROD_W'(mbe_pkg::SHADE_ONE))
                    ? mbe_pkg::SHADE_ONE : mbe_pkg::SHADE_W'(shade_prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      first_q <= 1'b0;
      esc_q   <= 1'b0;
    end else if (cmd_i.load) begin
      count_q <= '0;
      first_q <= 1'b1;
      esc_q   <= 1'b0;
    end else if (cmd_i.step) begin
      esc_q <= esc_hit;
      if (!esc_hit) begin
        count_q <= count_d;
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cr_q <= mbe_pkg::align_c(c_re_i);
      ci_q <= mbe_pkg::align_c(c_im_i);
      zr_q <= '0;
      zi_q <= '0;
    end
    if (cmd_i.step && !esc_hit) begin
      zr_q <= zr_d;
      zi_q <= zi_d;
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.mul_lo) begin
        plo_q[k] <= pp[k];
      end
      if (cmd_i.mul_hi) begin
        phi_q[k] <= pp[k];
      end
    end
    if (cmd_i.sum) begin
      rr_q <= prod[0];
      ii_q <= prod[1];
      ri_q <= ri_val;
    end
    if (cmd_i.out_load) begin
      iter_out_q  <= mbe_pkg::ITERS_W'(count_q);
      esc_out_q   <= esc_q;
      shade_out_q <= shade_sat;
    end
  end

  assign iterations_o = iter_out_q;
  assign escaped_o    = esc_out_q;
  assign shade_o      = shade_out_q;

endmodule

@@ rtl/mandelbrot_escape_time.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape-time iteration z = z*z + c for one point at a time, with an
// APB-style register port for bound, limit and shade scale
// ----------------------------------------------------------------------------
// iteration: a multiplier-half state for the low and the high halves, a product
//   sum state and an update state; a point that escapes runs one more iteration
//   than a point stopped by the limit at the same count
// throughput: one point at a time; the next beat can be taken in the cycle after the
//   result enters the output register, which holds it while the sink stalls
// reset: asynchronous, active low; registers return to 4.0, 256 and 1/256,
//   sequencer idle, output empty; no clearing pass
module mandelbrot_escape_time (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [mbe_pkg::C_W-1:0]     c_re_i,
  input  logic signed [mbe_pkg::C_W-1:0]     c_im_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mbe_pkg::ITERS_W-1:0]        iterations_o,
  output logic                               escaped_o,
  output logic [mbe_pkg::SHADE_W-1:0]        shade_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0]         paddr,
  input  logic [mbe_pkg::DATA_W-1:0]         pwdata,
  output logic [mbe_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  logic [mbe_pkg::ESC_W-1:0]     escape_sq_q;
  logic [mbe_pkg::LIM_W-1:0]     max_iter_q;
  logic [mbe_pkg::SCALE_W-1:0]   scale_factor_q;
  logic [mbe_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          reg_wr;
  mbe_pkg::cmd_t                 cmd;
  mbe_pkg::status_t              status;

  // registers sit on 8-byte steps; the low address bits are ignored
  assign pready  = 1'b1;
  assign reg_idx = paddr[mbe_pkg::ADDR_W-1:3];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_sq_q    <= mbe_pkg::ESCAPE_SQ_RST;
      max_iter_q     <= mbe_pkg::MAX_ITER_RST;
      scale_factor_q <= mbe_pkg::SCALE_FACTOR_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        mbe_pkg::REG_ESCAPE_SQ:    escape_sq_q    <= pwdata[mbe_pkg::ESC_W-1:0];
        mbe_pkg::REG_MAX_ITER:     max_iter_q     <= pwdata[mbe_pkg::LIM_W-1:0];
        mbe_pkg::REG_SCALE_FACTOR: scale_factor_q <= pwdata[mbe_pkg::SCALE_W-1:0];
        default: begin
          // unmapped address, write dropped
        end
      endcase
    end
  end

  // read-back
  always_comb begin
    unique case (reg_idx)
      mbe_pkg::REG_ESCAPE_SQ:    prdata = mbe_pkg::DATA_W'(escape_sq_q);
      mbe_pkg::REG_MAX_ITER:     prdata = mbe_pkg::DATA_W'(max_iter_q);
      mbe_pkg::REG_SCALE_FACTOR: prdata = mbe_pkg::DATA_W'(scale_factor_q);
      default:                   prdata = '0;
    endcase
  end

  // sequencer: one point in flight, four states per iteration
  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: z state, split multipliers, magnitude check, result register
  mbe_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .c_re_i         (c_re_i),
    .c_im_i         (c_im_i),
    .escape_sq_i    (escape_sq_q),
    .max_iter_i     (max_iter_q),
    .scale_factor_i (scale_factor_q),
    .iterations_o   (iterations_o),
    .escaped_o      (escaped_o),
    .shade_o        (shade_o)
  );

endmodule

@@ tb/mandelbrot_escape_time_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_checker
// watches the point, result and register channels, works out the escape
// count, escape flag and shade of every accepted point and compares them
// with the results in arrival order
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic signed [mbe_pkg::C_W-1:0]   c_re_i,
  input  logic signed [mbe_pkg::C_W-1:0]   c_im_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [mbe_pkg::ITERS_W-1:0]      iterations_i,
  input  logic                             escaped_i,
  input  logic [mbe_pkg::SHADE_W-1:0]      shade_i,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [mbe_pkg::ADDR_W-1:0]       paddr_i,
  input  logic [mbe_pkg::DATA_W-1:0]       pwdata_i,
  input  logic                             pready_i,
  output int                               pending_o,
  output int                               errors_o
);
  import mbe_pkg::*;

  typedef struct packed {
    logic [ITERS_W-1:0] iterations;
    logic               escaped;
    logic [SHADE_W-1:0] shade;
  } shading_t;

  localparam int ALIGN_UP   = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
  localparam int ALIGN_DOWN = (FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;
  localparam longint ZSAT_HI   = (64'sd1 <<< ZMAG_BITS) - 64'sd1;
  localparam longint ZSAT_LO   = -ZSAT_HI - 64'sd1;
  localparam longint COUNT_TOP = (64'sd1 <<< ITER_BITS) - 64'sd1;

  logic [ESC_W-1:0]   bound_reg;
  logic [LIM_W-1:0]   limit_reg;
  logic [SCALE_W-1:0] scale_reg;
  shading_t           awaited_shades [$];
  int                 points_in;
  int                 results_out;
  int                 errors;

  assign pending_o = points_in - results_out;
  assign errors_o  = errors;

  // product with the fraction shift, truncated toward zero
  function automatic longint frac_mul(input longint a, input longint b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    longint       r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = {64'd0, ma} * {64'd0, mb};
    r  = longint'(p >> FRAC_BITS);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint z_clamp(input longint x);
    if (x > ZSAT_HI) return ZSAT_HI;
    if (x < ZSAT_LO) return ZSAT_LO;
    return x;
  endfunction

  function automatic shading_t escape_time(input logic signed [C_W-1:0] re_in,
                                           input logic signed [C_W-1:0] im_in);
    longint      cr;
    longint      ci;
    longint      zr;
    longint      zi;
    longint      rr;
    longint      ii;
    longint      ri;
    longint      mag;
    longint      lim;
    longint      cnt;
    longint      bound;
    logic [63:0] tint;
    logic        hit;
    logic        done;
    shading_t    res;
    lim   = (longint'(limit_reg) < COUNT_TOP) ? longint'(limit_reg) : COUNT_TOP;
    bound = (longint'(bound_reg) << ALIGN_UP) >> ALIGN_DOWN;
    cr    = (longint'(re_in) <<< ALIGN_UP) >>> ALIGN_DOWN;
    ci    = (longint'(im_in) <<< ALIGN_UP) >>> ALIGN_DOWN;
    zr    = 0;
    zi    = 0;
    cnt   = 0;
    hit   = 1'b0;
    done  = 1'b0;
    while (!done) begin
      rr  = frac_mul(zr, zr);
      ii  = frac_mul(zi, zi);
      ri  = frac_mul(zr, zi);
      zr  = z_clamp(rr - ii + cr);
      zi  = z_clamp(2 * ri + ci);
      cnt = (cnt + 1) & COUNT_TOP;
      if (cnt >= lim) begin
        // limit reached, magnitude not looked at
        done = 1'b1;
      end else begin
        mag = frac_mul(zr, zr) + frac_mul(zi, zi);
        if (mag > ZSAT_HI) mag = ZSAT_HI;
        if (mag >= bound) begin
          hit  = 1'b1;
          done = 1'b1;
        end
      end
    end
    tint           = 64'(cnt) * 64'(scale_reg);
    res.iterations = ITERS_W'(cnt);
    res.escaped    = hit;
    res.shade      = (tint > 64'(SHADE_ONE)) ? SHADE_ONE : SHADE_W'(tint);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    shading_t want;
    int       bad;
    if (!rst_ni) begin
      bound_reg <= ESCAPE_SQ_RST;
      limit_reg <= MAX_ITER_RST;
      scale_reg <= SCALE_FACTOR_RST;
      awaited_shades.delete();
      points_in   <= 0;
      results_out <= 0;
      errors      <= 0;
    end else begin
      bad = 0;
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:3])
          REG_ESCAPE_SQ:    bound_reg <= ESC_W'(pwdata_i);
          REG_MAX_ITER:     limit_reg <= LIM_W'(pwdata_i);
          REG_SCALE_FACTOR: scale_reg <= SCALE_W'(pwdata_i);
          default: ;
        endcase
      end
      // results first, so a beat can never meet its own expectation early
      if (out_valid_i && !out_stall_i) begin
        results_out <= results_out + 1;
        if (awaited_shades.size() == 0) begin
          $error("result beat with no point waiting: iterations %0d", iterations_i);
          bad++;
        end else begin
          want = awaited_shades.pop_front();
          if (iterations_i !== want.iterations) begin
            $error("iterations: expected %0d, got %0d", want.iterations, iterations_i);
            bad++;
          end
          if (escaped_i !== want.escaped) begin
            $error("escaped: expected %0d, got %0d", want.escaped, escaped_i);
            bad++;
          end
          if (shade_i !== want.shade) begin
            $error("shade: expected 0x%0h, got 0x%0h", want.shade, shade_i);
            bad++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_shades.push_back(escape_time(c_re_i, c_im_i));
        points_in <= points_in + 1;
      end
      errors <= errors + bad;
    end
  end

endmodule

@@ tb/mandelbrot_escape_time_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// drives points and register settings into the escape-time unit with random
// gaps and sink stalls; a checker beside the unit predicts every result
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb;
  import mbe_pkg::*;

  // one in Q4.28
  localparam logic signed [C_W-1:0] Q_ONE = 32'sh1000_0000;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic signed [C_W-1:0]  c_re      = '0;
  logic signed [C_W-1:0]  c_im      = '0;
  logic                   out_stall = 1'b0;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [ADDR_W-1:0]      paddr     = '0;
  logic [DATA_W-1:0]      pwdata    = '0;
  logic                   in_stall;
  logic                   out_valid;
  logic [ITERS_W-1:0]     iterations;
  logic                   escaped;
  logic [SHADE_W-1:0]     shade;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  int   pending;
  int   errors;

  // idle chances in percent, changed only at clock edges
  int   send_idle_pct = 31;
  int   recv_idle_pct = 71;

  // one long sink hold-off, counted in the sink process
  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mandelbrot_escape_time uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .c_re_i       (c_re),
    .c_im_i       (c_im),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .iterations_o (iterations),
    .escaped_o    (escaped),
    .shade_o      (shade),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mandelbrot_escape_time_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .c_re_i       (c_re),
    .c_im_i       (c_im),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .iterations_i (iterations),
    .escaped_i    (escaped),
    .shade_i      (shade),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  // sink side: random stalls, or the long hold-off once it is asked for
  always @(posedge clk) begin : sink
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = 2000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offers one point and returns at the edge where the beat is taken;
  // valid is only lowered when an idle cycle is actually inserted
  task automatic send_point(input logic signed [C_W-1:0] re,
                            input logic signed [C_W-1:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    c_re     <= re;
    c_im     <= im;
    do @(posedge clk); while (in_stall);
  endtask

  // stops offering and waits until every point has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending > 0);
  endtask

  // setup then access phase, register index sits above the byte offset
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // only ever called with the unit idle
  task automatic set_config(input logic [ESC_W-1:0]   bound,
                            input logic [LIM_W-1:0]   lim,
                            input logic [SCALE_W-1:0] scale);
    drain();
    write_reg(REG_ESCAPE_SQ, DATA_W'(bound));
    write_reg(REG_MAX_ITER, DATA_W'(lim));
    write_reg(REG_SCALE_FACTOR, DATA_W'(scale));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [C_W-1:0] corner_value(input int k);
    case (k)
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      default: return '0;
    endcase
  endfunction

  initial begin : stimulus
    logic signed [C_W-1:0] re;
    logic signed [C_W-1:0] im;
    logic [ESC_W-1:0]      bound;
    logic [LIM_W-1:0]      lim;
    logic [SCALE_W-1:0]    scale;
    int                    sent;
    int                    n;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: bound 4.0, limit 256, shade 1/256
    send_point(0, 0);                                   // never escapes, full limit
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000);         // field extremes
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(-2 * Q_ONE, 0);                          // |z|^2 lands on the bound
    send_point(Q_ONE / 4, 0);                           // cusp of the main cardioid
    send_point(-Q_ONE, 0);                              // period-two orbit
    send_point(0, Q_ONE);                               // bounded orbit on the axis
    send_point(-3 * Q_ONE / 4, Q_ONE / 10);             // slow escape near the neck
    send_point(-32'sd1, -32'sd1);                       // tiny negative c, truncation

    // zero bound, zero limit treated as one, zero shade
    set_config('0, '0, '0);
    send_point(0, 0);
    send_point(Q_ONE, -Q_ONE);

    // widest bound: z and |z|^2 saturate, shade scale above 1.0
    set_config('1, 16'd200, '1);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(-2 * Q_ONE, 0);

    // zero bound escapes on the first check, shade exactly 1.0
    set_config('0, 16'd10, SCALE_W'(1 << 24));
    send_point(0, 0);
    send_point(Q_ONE / 2, -Q_ONE / 2);

    // limit of one: no magnitude check at all
    set_config(ESCAPE_SQ_RST, 16'd1, SCALE_W'(12345));
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(0, 0);

    // widest limit, one long inside point and one quick escape
    set_config(ESCAPE_SQ_RST, '1, SCALE_W'(1));
    send_point(0, 0);
    send_point(Q_ONE, Q_ONE);

    // random phases, each under a fresh setting
    sent = 0;
    while (sent < 850) begin
      if (sent >= 566) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end else if (sent >= 283) begin
        send_idle_pct <= 71;
        recv_idle_pct <= 31;
      end

      case ($urandom_range(5))
        0:       bound = ESCAPE_SQ_RST;
        1:       bound = ESC_W'({2'($urandom_range(3)), $urandom});
        2:       bound = '0;
        3:       bound = '1;
        default: bound = ESC_W'($urandom_range(32'h1000_0000, 32'hFFFF_FFFF));
      endcase
      // mostly short limits so the run stays quick
      case ($urandom_range(9))
        0:       lim = LIM_W'($urandom_range(1, 3));
        1:       lim = MAX_ITER_RST;
        default: lim = LIM_W'($urandom_range(4, 40));
      endcase
      case ($urandom_range(4))
        0:       scale = '0;
        1:       scale = SCALE_W'(1 << 24);
        2:       scale = '1;
        default: scale = SCALE_W'($urandom_range(0, 32'h0010_0000));
      endcase
      set_config(bound, lim, scale);

      // with no sender gaps, hold the sink off so the unit backs up
      if (sent >= 566 && !hold_req) hold_req <= 1'b1;

      n = $urandom_range(30, 70);
      repeat (n) begin
        case ($urandom_range(9))
          0: begin
            re = $urandom;
            im = $urandom;
          end
          1: begin
            re = corner_value($urandom_range(3));
            im = corner_value($urandom_range(3));
          end
          default: begin
            // window around the set: re in [-2.5, 1.0], im in [-1.5, 1.5]
            re = $signed($urandom_range(0, 32'h3800_0000)) - 32'sh2800_0000;
            im = $signed($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000;
          end
        endcase
        send_point(re, im);
        sent++;
      end
    end

    // let everything come back, then a little longer for stray beats
    drain();
    repeat (64) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard limit on the run, well beyond the slowest legal run
  initial begin : watchdog
    #25_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mbe_pkg.sv
rtl/mbe_ctrl.sv
rtl/mbe_dp.sv
rtl/mandelbrot_escape_time.sv
tb/mandelbrot_escape_time_checker.sv
tb/mandelbrot_escape_time_tb.sv
